[design/rtc_pkg.sv]
package rtc_pkg;

   localparam int MAX_TOGGLES_DEFAULT = 64;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   localparam logic [1:0] REG_MODE    = 2'd0;
   localparam logic [1:0] REG_CONTROL = 2'd1;
   localparam logic [1:0] REG_TIME    = 2'd2;
   localparam logic [1:0] REG_DATE    = 2'd3;

   localparam logic [1:0] CSR_RUN_THRESHOLD    = 2'd0;
   localparam logic [1:0] CSR_PAUSED_THRESHOLD = 2'd1;

   localparam logic [23:0] THRESHOLD_RESET = 24'd16384;
   localparam logic [31:0] TIME_RESET      = 32'h0400_0000;
   localparam logic [31:0] DATE_RESET      = 32'h0098_0101;

   typedef struct packed {
      logic [1:0]  op;
      logic [1:0]  reg_sel;
      logic [1:0]  lane;
      logic [7:0]  data;
      logic [15:0] cycles;
   } entry_type;

endpackage

[design/bcd_rtc_with_register_port.sv]
// a register access passes from the queue into the item register; its result is registered
// a tick first adds its cycles to the accumulator, then gives one result per cycle per toggle,
// held while the DAY_A and DAY_B states update the calendar when a second rolls over midnight
// the back end takes a new request only when idle, so it finishes each access or tick first
// a 2-entry request queue holds requests while the back end works; busy is high when it is full
// reset is synchronous; it restores the registers, clock and calendar and empties the queue
module bcd_rtc_with_register_port
   import rtc_pkg::*;
#(
   parameter int MAX_TOGGLES_PER_TICK = MAX_TOGGLES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [3:0]  req_offset,
   input  logic [7:0]  req_write_byte,
   input  logic [15:0] req_cycles,
   output logic        rsp_valid,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_int_level,
   output logic        rsp_toggled,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_data
);

   logic      q_full;
   logic      q_empty;
   logic      push;
   logic      pop;
   entry_type push_entry;
   entry_type pop_entry;

   assign csr_ready = 1'b1;

   rtc_front u_front (
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_offset     (req_offset),
      .req_write_byte (req_write_byte),
      .req_cycles     (req_cycles),
      .q_full         (q_full),
      .push           (push),
      .push_entry     (push_entry)
   );

   rtc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .full       (q_full),
      .empty      (q_empty)
   );

   rtc_back #(
      .MAX_TOGGLES_PER_TICK (MAX_TOGGLES_PER_TICK)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_entry       (pop_entry),
      .pop           (pop),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .rsp_valid     (rsp_valid),
      .rsp_read_data (rsp_read_data),
      .rsp_int_level (rsp_int_level),
      .rsp_toggled   (rsp_toggled),
      .rsp_last      (rsp_last)
   );

endmodule

[design/rtc_front.sv]
module rtc_front
   import rtc_pkg::*;
(
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [3:0]  req_offset,
   input  logic [7:0]  req_write_byte,
   input  logic [15:0] req_cycles,
   input  logic        q_full,
   output logic        push,
   output entry_type   push_entry
);

   always_comb begin
      push_entry.reg_sel = req_offset[3:2];
      push_entry.lane    = req_offset[1:0];
      push_entry.data    = req_write_byte;
      push_entry.cycles  = req_cycles;
      case (req_action)
         OP_READ: begin
            push_entry.op = OP_READ;
         end
         OP_WRITE: begin
            push_entry.op = OP_WRITE;
         end
         OP_TICK: begin
            push_entry.op = OP_TICK;
         end
         default: begin
            push_entry.op = OP_NONE;
         end
      endcase
   end

   assign busy = q_full;
   assign push = start & ~q_full;

endmodule

[design/rtc_queue.sv]
module rtc_queue
   import rtc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type pop_entry,
   output logic      full,
   output logic      empty
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type        mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign pop_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[design/rtc_back.sv]
module rtc_back
   import rtc_pkg::*;
#(
   parameter int MAX_TOGGLES_PER_TICK = MAX_TOGGLES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_empty,
   input  entry_type   q_entry,
   output logic        pop,
   input  logic        csr_valid,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_data,
   output logic        rsp_valid,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_int_level,
   output logic        rsp_toggled,
   output logic        rsp_last
);

   localparam int CNT_W = (MAX_TOGGLES_PER_TICK > 1) ? $clog2(MAX_TOGGLES_PER_TICK) : 1;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_EXEC  = 3'd1;
   localparam logic [2:0] ST_LOOP  = 3'd2;
   localparam logic [2:0] ST_DAY_A = 3'd3;
   localparam logic [2:0] ST_DAY_B = 3'd4;

   localparam logic [2:0] FLD_SEC   = 3'd0;
   localparam logic [2:0] FLD_MIN   = 3'd1;
   localparam logic [2:0] FLD_HOUR  = 3'd2;
   localparam logic [2:0] FLD_WDAY  = 3'd3;
   localparam logic [2:0] FLD_DAY   = 3'd4;
   localparam logic [2:0] FLD_MONTH = 3'd5;
   localparam logic [2:0] FLD_YEAR  = 3'd6;

   typedef struct packed {
      logic        roll;
      logic [31:0] value;
   } sec_type;

   function automatic logic [31:0] wday_step(input logic [31:0] t_in);
      logic [31:0] t;
      t = t_in + 32'h0100_0000;
      if (t[27:24] == 4'h8) begin
         t = {t[31:28], 4'h1, t[23:0]};
      end
      return t;
   endfunction

   function automatic sec_type sec_step(input logic [31:0] t_in);
      sec_type r;
      r.roll  = 1'b0;
      r.value = t_in + 32'h1;
      if (r.value[3:0] == 4'hA) begin
         r.value = {r.value[31:4], 4'h0} + 32'h10;
         if (r.value[7:0] == 8'h60) begin
            r.value = {r.value[31:8], 8'h00} + 32'h100;
            if (r.value[11:8] == 4'hA) begin
               r.value = {r.value[31:12], 4'h0, r.value[7:0]} + 32'h1000;
               if (r.value[15:8] == 8'h60) begin
                  r.value = {r.value[31:16], 8'h00, r.value[7:0]} + 32'h1_0000;
                  if (r.value[23:16] == 8'h24) begin
                     r.value = wday_step({r.value[31:24], 8'h00, r.value[15:0]});
                     r.roll  = 1'b1;
                  end else if (r.value[19:16] == 4'hA) begin
                     r.value = {r.value[31:20], 4'h0, r.value[15:0]} + 32'h10_0000;
                  end
               end
            end
         end
      end
      return r;
   endfunction

   function automatic logic [31:0] field_time(input logic [2:0] sel, input logic [31:0] t_in);
      logic [31:0] t;
      t = t_in;
      case (sel)
         FLD_SEC: begin
            t = t + 32'h1;
            if (t[3:0] == 4'hA) begin
               t = {t[31:4], 4'h0} + 32'h10;
               if (t[7:0] == 8'h60) t = {t[31:8], 8'h00};
            end
         end
         FLD_MIN: begin
            t = t + 32'h100;
            if (t[11:8] == 4'hA) begin
               t = {t[31:12], 4'h0, t[7:0]} + 32'h1000;
               if (t[15:8] == 8'h60) t = {t[31:16], 8'h00, t[7:0]};
            end
         end
         FLD_HOUR: begin
            t = t + 32'h1_0000;
            if (t[23:16] == 8'h24) begin
               t = {t[31:24], 8'h00, t[15:0]};
            end else if (t[19:16] == 4'hA) begin
               t = {t[31:20], 4'h0, t[15:0]} + 32'h10_0000;
            end
         end
         FLD_WDAY: begin
            t = wday_step(t);
         end
         default: begin
            t = t_in;
         end
      endcase
      return t;
   endfunction

   function automatic logic [31:0] field_date(input logic [2:0] sel, input logic [31:0] d_in);
      logic [31:0] d;
      d = d_in;
      case (sel)
         FLD_DAY: begin
            d = d + 32'h1;
            if (d[7:0] == 8'h32) begin
               d = {d[31:8], 8'h00};
            end else if (d[3:0] == 4'hA) begin
               d = {d[31:4], 4'h0} + 32'h10;
            end
         end
         FLD_MONTH: begin
            d = d + 32'h100;
            if (d[15:8] == 8'h13) begin
               d = {d[31:8], 8'h01};
            end else if (d[11:8] == 4'hA) begin
               d = {d[31:12], 4'h0, d[7:0]} + 32'h1000;
            end
         end
         FLD_YEAR: begin
            d = d + 32'h1_0000;
            if (d[19:16] == 4'hA) begin
               d = {d[31:20], 4'h0, d[15:0]} + 32'h10_0000;
               if (d[23:20] == 4'hA) d = {d[31:24], 8'h00, d[15:0]};
            end
         end
         default: begin
            d = d_in;
         end
      endcase
      return d;
   endfunction

   function automatic logic [7:0] bcd_dec(input logic [7:0] b);
      return {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0} + {4'h0, b[3:0]};
   endfunction

   function automatic logic [7:0] bcd_enc(input logic [7:0] v);
      logic [15:0] p;
      logic [4:0]  q;
      logic [7:0]  r;
      p = {8'h00, v} * 16'd205;
      q = p[15:11];
      r = v - ({3'b000, q} * 8'd10);
      return {q[3:0], r[3:0]};
   endfunction

   function automatic logic [7:0] month_len(input logic [7:0] m, input logic [7:0] y);
      logic [7:0] len;
      case (m)
         8'd2:    len = (y[1:0] == 2'b00) ? 8'd29 : 8'd28;
         8'd4:    len = 8'd30;
         8'd6:    len = 8'd30;
         8'd9:    len = 8'd30;
         8'd11:   len = 8'd30;
         default: len = 8'd31;
      endcase
      return len;
   endfunction

   logic [2:0]       state_ff, state_in;
   entry_type        item_ff, item_in;
   logic [31:0]      mode_ff, mode_in;
   logic [7:0]       control_ff, control_in;
   logic [31:0]      time_ff, time_in;
   logic [31:0]      date_ff, date_in;
   logic [31:0]      acc_ff, acc_in;
   logic             irq_ff, irq_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [23:0]      run_th_ff, run_th_in;
   logic [23:0]      pause_th_ff, pause_th_in;
   logic [7:0]       nd_ff, nd_in;
   logic [7:0]       nm_ff, nm_in;
   logic [7:0]       ny_ff, ny_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_data_ff, rsp_data_in;
   logic             rsp_irq_ff, rsp_irq_in;
   logic             rsp_tog_ff, rsp_tog_in;
   logic             rsp_last_ff, rsp_last_in;

   logic [31:0] reg_view;
   logic [32:0] acc_sum;
   logic [23:0] th;
   logic        hit;
   logic        hit2;
   logic        last_tog;
   logic        irq_new;
   logic        fld_ok;
   sec_type     sec;
   logic [7:0]  dd, dm, dy;
   logic [7:0]  d_inc, m_inc, y_inc;
   logic        day_wrap;

   always_comb begin
      case (item_ff.reg_sel)
         REG_MODE:    reg_view = mode_ff;
         REG_CONTROL: reg_view = {24'h0, control_ff};
         REG_TIME:    reg_view = time_ff;
         default:     reg_view = date_ff;
      endcase
   end

   assign acc_sum  = {1'b0, acc_ff} + {17'h0, item_ff.cycles};
   assign th       = mode_ff[0] ? pause_th_ff : run_th_ff;
   assign hit      = (acc_ff >= {8'h00, th});
   assign hit2     = (acc_ff >= {7'h00, th, 1'b0});
   assign last_tog = (cnt_ff == CNT_W'(MAX_TOGGLES_PER_TICK - 1)) || !hit2;
   assign irq_new  = ~irq_ff;
   assign fld_ok   = (mode_ff[31:4] == 28'h0) && (mode_ff[3:1] != 3'd7);
   assign sec      = sec_step(time_ff);

   assign dd       = bcd_dec(date_ff[7:0]);
   assign dm       = bcd_dec(date_ff[15:8]);
   assign dy       = bcd_dec(date_ff[23:16]);
   assign d_inc    = dd + 8'd1;
   assign m_inc    = dm + 8'd1;
   assign y_inc    = (dy + 8'd1 >= 8'd100) ? dy + 8'd1 - 8'd100 : dy + 8'd1;
   assign day_wrap = (d_inc > month_len(dm, dy));

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      mode_in      = mode_ff;
      control_in   = control_ff;
      time_in      = time_ff;
      date_in      = date_ff;
      acc_in       = acc_ff;
      irq_in       = irq_ff;
      cnt_in       = cnt_ff;
      done_in      = done_ff;
      run_th_in    = run_th_ff;
      pause_th_in  = pause_th_ff;
      nd_in        = nd_ff;
      nm_in        = nm_ff;
      ny_in        = ny_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = 8'h00;
      rsp_irq_in   = irq_ff;
      rsp_tog_in   = 1'b0;
      rsp_last_in  = 1'b1;
      pop          = 1'b0;

      if (csr_valid) begin
         if (csr_index == CSR_RUN_THRESHOLD) run_th_in = csr_data;
         if (csr_index == CSR_PAUSED_THRESHOLD) pause_th_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               pop      = 1'b1;
               item_in  = q_entry;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (item_ff.op)
               OP_READ: begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = reg_view[{item_ff.lane, 3'b000} +: 8];
                  state_in     = ST_IDLE;
               end
               OP_WRITE: begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
                  case (item_ff.reg_sel)
                     REG_MODE: begin
                        mode_in[{item_ff.lane, 3'b000} +: 8] = item_ff.data;
                     end
                     REG_TIME: begin
                        time_in[{item_ff.lane, 3'b000} +: 8] = item_ff.data;
                     end
                     REG_DATE: begin
                        date_in[{item_ff.lane, 3'b000} +: 8] = item_ff.data;
                     end
                     default: begin
                        if (item_ff.lane == 2'd0) begin
                           if (control_ff == 8'd1 && item_ff.data == 8'd1) begin
                              if (fld_ok) begin
                                 time_in = field_time(mode_ff[3:1], time_ff);
                                 date_in = field_date(mode_ff[3:1], date_ff);
                              end
                              control_in = 8'd0;
                           end else if (control_ff == 8'd0) begin
                              control_in = item_ff.data;
                           end
                        end
                     end
                  endcase
               end
               OP_TICK: begin
                  acc_in   = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
                  cnt_in   = '0;
                  state_in = ST_LOOP;
               end
               default: begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            endcase
         end
         ST_LOOP: begin
            rsp_valid_in = 1'b1;
            if (!hit) begin
               state_in = ST_IDLE;
            end else begin
               acc_in      = acc_ff - {8'h00, th};
               irq_in      = irq_new;
               rsp_irq_in  = irq_new;
               rsp_tog_in  = 1'b1;
               rsp_last_in = last_tog;
               cnt_in      = cnt_ff + CNT_W'(1);
               done_in     = last_tog;
               state_in    = last_tog ? ST_IDLE : ST_LOOP;
               if (!mode_ff[0] && !irq_new) begin
                  time_in = sec.value;
                  if (sec.roll) state_in = ST_DAY_A;
               end
            end
         end
         ST_DAY_A: begin
            nd_in = day_wrap ? 8'd1 : d_inc;
            nm_in = dm;
            ny_in = dy;
            if (day_wrap) begin
               if (m_inc > 8'd12) begin
                  nm_in = 8'd1;
                  ny_in = y_inc;
               end else begin
                  nm_in = m_inc;
               end
            end
            state_in = ST_DAY_B;
         end
         ST_DAY_B: begin
            date_in  = {date_ff[31:24], bcd_enc(ny_ff), bcd_enc(nm_ff), bcd_enc(nd_ff)};
            state_in = done_ff ? ST_IDLE : ST_LOOP;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= '0;
         control_ff   <= '0;
         time_ff      <= TIME_RESET;
         date_ff      <= DATE_RESET;
         acc_ff       <= '0;
         irq_ff       <= 1'b0;
         cnt_ff       <= '0;
         done_ff      <= 1'b0;
         run_th_ff    <= THRESHOLD_RESET;
         pause_th_ff  <= THRESHOLD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         control_ff   <= control_in;
         time_ff      <= time_in;
         date_ff      <= date_in;
         acc_ff       <= acc_in;
         irq_ff       <= irq_in;
         cnt_ff       <= cnt_in;
         done_ff      <= done_in;
         run_th_ff    <= run_th_in;
         pause_th_ff  <= pause_th_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      nd_ff       <= nd_in;
      nm_ff       <= nm_in;
      ny_ff       <= ny_in;
      rsp_data_ff <= rsp_data_in;
      rsp_irq_ff  <= rsp_irq_in;
      rsp_tog_ff  <= rsp_tog_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_int_level = rsp_irq_ff;
   assign rsp_toggled   = rsp_tog_ff;
   assign rsp_last      = rsp_last_ff;

endmodule
